/* rtl/core/swt_pkg.sv */
// Shared types, constants and character helpers for the sorted word table.
// No dependencies.
package swt_pkg;

    localparam int CAPACITY   = 64;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int TOTAL_W    = $clog2(CAPACITY + 1);
    localparam int KEY_LIMIT  = 4;
    localparam int ENTRY_W    = 32 + 3 + 8;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_SEARCH = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_LIST   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_NOMATCH = 2'd2,
        ST_CLEARED = 2'd3
    } status_t;

    typedef struct packed {
        logic [31:0] chars;
        logic [2:0]  count;
        logic [7:0]  length;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load_req;   // capture the incoming request
        logic             rd_en;      // read memory at rd_addr
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;      // write memory at wr_addr
        logic [IDX_W-1:0] wr_addr;
        logic             wr_new;     // write the new key instead of read data
        logic             take_rd;    // latch read data into the hold register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic        rd_greater;  // freshly read entry sorts after the request key
        logic        rd_match;    // freshly read entry matches the search prefix
        logic [2:0]  key_count;
        op_t         op;
    } dp_stat_t;

    function automatic logic [7:0] fold_char(input logic [7:0] c);
        fold_char = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function automatic logic [7:0] char_at(input logic [31:0] k, input int i);
        char_at = k[31-8*i -: 8];
    endfunction

endpackage

/* rtl/core/swt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module swt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/core/swt_datapath.sv */
// Datapath: request registers, table memory, compare logic.
// Depends on swt_pkg and swt_ram.
module swt_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       in_op,
    input  logic [31:0]      in_chars,
    input  logic [2:0]       in_count,
    input  logic [7:0]       in_length,
    input  logic             in_exact,
    input  swt_pkg::dp_cmd_t cmd,
    output swt_pkg::dp_stat_t stat,
    output swt_pkg::entry_t  hold_entry,
    output swt_pkg::entry_t  new_entry
);
    import swt_pkg::*;

    op_t         op_reg;
    logic [31:0] key_reg;
    logic [2:0]  cnt_reg;
    logic [7:0]  len_reg;
    logic        exact_reg;
    entry_t      hold_reg;
    logic [ENTRY_W-1:0] rd_data;
    logic [ENTRY_W-1:0] wr_data;
    logic [2:0]  cnt_cut;
    logic [31:0] key_cut;

    always_comb
    begin
        cnt_cut = (in_count > 3'(KEY_LIMIT)) ? 3'(KEY_LIMIT) : in_count;
        case (cnt_cut)
            3'd0:    key_cut = 32'h0;
            3'd1:    key_cut = {in_chars[31:24], 24'h0};
            3'd2:    key_cut = {in_chars[31:16], 16'h0};
            3'd3:    key_cut = {in_chars[31:8], 8'h0};
            default: key_cut = in_chars;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= OP_ADD;
        end
        else if (cmd.load_req)
        begin
            op_reg <= op_t'(in_op);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            key_reg   <= key_cut;
            cnt_reg   <= cnt_cut;
            len_reg   <= in_length;
            exact_reg <= in_exact;
        end
        if (cmd.take_rd)
        begin
            hold_reg <= entry_t'(rd_data);
        end
    end

    // An entry being moved up is written straight from the read data.
    assign new_entry = '{chars: key_reg, count: cnt_reg, length: len_reg};
    assign wr_data   = cmd.wr_new ? ENTRY_W'(new_entry) : rd_data;

    swt_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (cmd.wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (cmd.rd_addr),
        .rd_data (rd_data)
    );

    // Compare the freshly read entry against the request key.
    always_comb
    begin
        logic       decided;
        logic       gt;
        logic       ok;
        logic [7:0] a;
        logic [7:0] b;
        logic [2:0] n;
        entry_t     e;
        e       = entry_t'(rd_data);
        decided = 1'b0;
        gt      = 1'b0;
        ok      = (e.count >= cnt_reg);
        n       = (e.count < cnt_reg) ? e.count : cnt_reg;
        for (int i = 0; i < KEY_LIMIT; i++)
        begin
            a = fold_char(char_at(e.chars, i));
            b = fold_char(char_at(key_reg, i));
            if (!decided && 3'(i) < n && a != b)
            begin
                decided = 1'b1;
                gt      = a > b;
            end
            if (!exact_reg)
            begin
                if (3'(i) < cnt_reg && a != b) ok = 1'b0;
            end
            else
            begin
                if (3'(i) < cnt_reg && char_at(e.chars, i) != char_at(key_reg, i)) ok = 1'b0;
            end
        end
        if (!decided)
        begin
            gt = e.count > cnt_reg;
        end
        stat.rd_greater = gt;
        stat.rd_match   = ok;
        stat.key_count  = cnt_reg;
        stat.op         = op_reg;
    end

    assign hold_entry = hold_reg;

endmodule

/* rtl/core/swt_ctrl.sv */
// Controller state machine: walks the table, sequences inserts and output.
// Depends on swt_pkg.
module swt_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  swt_pkg::dp_stat_t          stat,
    output swt_pkg::dp_cmd_t           cmd,
    output logic                       res_push,
    output logic                       res_from_mem,
    output logic                       res_last,
    output swt_pkg::status_t           res_status,
    input  logic                       res_free
);
    import swt_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DISP  = 7'b0000010,
        S_SCAN  = 7'b0000100,  // read data valid for index idx_reg
        S_SHIFT = 7'b0001000,  // read data of idx_reg moves up to idx_reg + 1
        S_PUT   = 7'b0010000,  // write the new entry at idx_reg
        S_EMIT  = 7'b0100000,  // push the pending status; a stored add also echoes the new entry
        S_END   = 7'b1000000   // push the held match as the final result
    } state_t;

    state_t             state_reg, state_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [TOTAL_W-1:0] idx_reg, idx_next;
    logic [TOTAL_W-1:0] ins_reg, ins_next;
    logic               found_reg, found_next;
    status_t            pend_st_reg, pend_st_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            total_reg   <= '0;
            idx_reg     <= '0;
            ins_reg     <= '0;
            found_reg   <= 1'b0;
            pend_st_reg <= ST_DONE;
        end
        else
        begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            idx_reg     <= idx_next;
            ins_reg     <= ins_next;
            found_reg   <= found_next;
            pend_st_reg <= pend_st_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        logic [TOTAL_W-1:0] nxt;
        logic               hit;
        logic               at_end;
        state_next   = state_reg;
        total_next   = total_reg;
        idx_next     = idx_reg;
        ins_next     = ins_reg;
        found_next   = found_reg;
        pend_st_next = pend_st_reg;
        cmd          = '0;
        res_push     = 1'b0;
        res_from_mem = 1'b0;
        res_last     = 1'b1;
        res_status   = pend_st_reg;
        nxt          = idx_reg + TOTAL_W'(1);
        hit          = (stat.op == OP_LIST) || stat.rd_match;
        at_end       = (nxt == total_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DISP;
                end
            end
            S_DISP:
            begin
                idx_next   = '0;
                found_next = 1'b0;
                unique case (stat.op) inside
                    OP_CLEAR:
                    begin
                        total_next   = '0;
                        pend_st_next = ST_CLEARED;
                        state_next   = S_EMIT;
                    end
                    OP_ADD:
                    begin
                        if (total_reg == TOTAL_W'(CAPACITY))
                        begin
                            pend_st_next = ST_FULL;
                            state_next   = S_EMIT;
                        end
                        else if (total_reg == '0)
                        begin
                            state_next = S_PUT;
                        end
                        else
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_addr = '0;
                            state_next  = S_SCAN;
                        end
                    end
                    OP_SEARCH, OP_LIST:
                    begin
                        if (total_reg == '0 || (stat.op == OP_SEARCH && stat.key_count == '0))
                        begin
                            pend_st_next = ST_NOMATCH;
                            state_next   = S_EMIT;
                        end
                        else
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_addr = '0;
                            state_next  = S_SCAN;
                        end
                    end
                endcase
            end
            S_SCAN:
            begin
                if (stat.op == OP_ADD)
                begin
                    if (stat.rd_greater)
                    begin
                        // Insert here: move entries up, starting from the top one.
                        ins_next    = idx_reg;
                        idx_next    = total_reg - TOTAL_W'(1);
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = IDX_W'(total_reg - TOTAL_W'(1));
                        state_next  = S_SHIFT;
                    end
                    else if (at_end)
                    begin
                        idx_next   = nxt;
                        state_next = S_PUT;
                    end
                    else
                    begin
                        idx_next    = nxt;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = IDX_W'(nxt);
                    end
                end
                else if (hit && found_reg && !res_free)
                begin
                    // The held match cannot leave yet; the read data stays put.
                    state_next = S_SCAN;
                end
                else
                begin
                    // Each match waits in the hold register until the next one
                    // or the end of the walk shows whether it is the last.
                    if (hit)
                    begin
                        cmd.take_rd = 1'b1;
                        found_next  = 1'b1;
                        if (found_reg)
                        begin
                            res_push     = 1'b1;
                            res_from_mem = 1'b1;
                            res_last     = 1'b0;
                            res_status   = ST_DONE;
                        end
                    end
                    if (at_end)
                    begin
                        if (hit || found_reg)
                        begin
                            state_next = S_END;
                        end
                        else
                        begin
                            pend_st_next = ST_NOMATCH;
                            state_next   = S_EMIT;
                        end
                    end
                    else
                    begin
                        idx_next    = nxt;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = IDX_W'(nxt);
                    end
                end
            end
            S_SHIFT:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = IDX_W'(idx_reg + TOTAL_W'(1));
                if (idx_reg == ins_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    idx_next    = idx_reg - TOTAL_W'(1);
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = IDX_W'(idx_reg - TOTAL_W'(1));
                end
            end
            S_PUT:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_new   = 1'b1;
                cmd.wr_addr  = IDX_W'(idx_reg);
                total_next   = total_reg + TOTAL_W'(1);
                pend_st_next = ST_DONE;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (res_free)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_END:
            begin
                if (res_free)
                begin
                    res_push     = 1'b1;
                    res_from_mem = 1'b1;
                    res_status   = ST_DONE;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/sorted_word_table_prefix_search.sv */
// Top level of the sorted word table with prefix search.
// Depends on swt_pkg, swt_ctrl, swt_datapath and swt_ram.
//
// The block keeps up to 64 words in one RAM, sorted by case-insensitive key,
// and takes one request at a time (add, prefix search, clear, list). A
// request is taken only when the previous one has pushed its last result
// into the output register. The controller walks the single RAM port, one
// entry per cycle: an add scans up to its insertion point and then moves the
// later entries up by one; a search or list visits every stored entry, and
// its walk holds while the output register is not free. Each match is held
// back until the next match or the end of the walk shows whether it is the
// last one. Results sit in an output register, so a stalled consumer only
// holds the walk, never loses a result.
module sorted_word_table_prefix_search (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // op[1:0], key_chars[33:2], key_count[36:34],
                                        // word_length[44:37], case_exact[45], zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // status[1:0], entry_chars[33:2],
                                        // entry_count[36:34], entry_length[44:37], zero fill
    output logic        m_axis_tlast
);
    import swt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    entry_t   hold_entry;
    entry_t   new_entry;
    logic     res_push;
    logic     res_from_mem;
    logic     res_last;
    status_t  res_status;
    logic     res_free;
    logic     out_valid_reg;
    logic [44:0] out_data_reg;
    logic     out_last_reg;

    swt_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_op      (s_axis_tdata[1:0]),
        .in_chars   (s_axis_tdata[33:2]),
        .in_count   (s_axis_tdata[36:34]),
        .in_length  (s_axis_tdata[44:37]),
        .in_exact   (s_axis_tdata[45]),
        .cmd        (cmd),
        .stat       (stat),
        .hold_entry (hold_entry),
        .new_entry  (new_entry)
    );

    swt_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .stat         (stat),
        .cmd          (cmd),
        .res_push     (res_push),
        .res_from_mem (res_from_mem),
        .res_last     (res_last),
        .res_status   (res_status),
        .res_free     (res_free)
    );

    assign res_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Matches and listed entries come from the hold register; a successful
    // add echoes the request as stored; every other result is a bare status.
    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            out_last_reg <= res_last;
            if (res_from_mem)
            begin
                out_data_reg <= {hold_entry.length, hold_entry.count,
                                 hold_entry.chars, res_status};
            end
            else if (res_status == ST_DONE && stat.op == OP_ADD)
            begin
                out_data_reg <= {new_entry.length, new_entry.count,
                                 new_entry.chars, res_status};
            end
            else
            begin
                out_data_reg <= {43'h0, res_status};
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'h0, out_data_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule
